@@ src/bia_pkg.sv @@
// Shared constants, codes and types of the bitmap indexed block allocator.
// Used by bia_scan and bitmap_indexed_block_allocator; depends on nothing.
`default_nettype none

package bia_pkg;

    localparam int NUM_BLOCKS_DEF = 128;
    localparam int MAX_DATA_DEF   = 4;

    localparam int CHUNK_W   = 16;
    localparam int OFF_W     = $clog2(CHUNK_W);
    localparam int OUT_SLOTS = 4;

    localparam int BLK_NUM_W = 7;
    localparam int COUNT_W   = 3;
    localparam int FREE_W    = 8;
    localparam int CODE_W    = 8;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    localparam logic [CODE_W-1:0] CODE_UNUSED = 8'hFF;
    localparam logic [CODE_W-1:0] CODE_DATA   = 8'hFE;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef logic [CODE_W-1:0] code_t;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] off;
    } scan_res_t;

endpackage

`default_nettype wire

@@ src/bia_ram.sv @@
// Generic simple dual-port RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module bia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/bia_scan.sv @@
// Find-first-free unit: lowest clear bit of one chunk of the used bitmap.
// Depends on bia_pkg.
`default_nettype none

module bia_scan (
    input  logic [bia_pkg::CHUNK_W-1:0] used_bits,
    output bia_pkg::scan_res_t          res
);

    localparam int CW = bia_pkg::CHUNK_W;
    localparam int OW = bia_pkg::OFF_W;

    always_comb
    begin
        res = '0;
        for (int i = CW - 1; i >= 0; i--)
        begin
            if (!used_bits[i])
            begin
                res.found = 1'b1;
                res.off   = OW'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/bitmap_indexed_block_allocator.sv @@
// Top level of the bitmap indexed block allocator: sequencer, bitmap, row store.
// Depends on bia_pkg, bia_scan and bia_ram.
//
//  channel  | direction | contents
//  s_axis   | in        | tuser: req_type; tdata: block_count, head_block
//  m_axis   | out       | tuser: status; tdata: granted_head, data_block_0..3, free_blocks
//
// Allocate: check, scan of the bitmap in 16-block chunks, head row read and write.
// Free: check, head row read, one index row entry walked per cycle, head row write.
// Refused allocate or out-of-range free: check goes straight to output. One request at a time.
// Reset clears the used bitmap and row valid bits at once; no clearing pass.
// A stalled result holds on m_axis and input stays blocked until it transfers.
`default_nettype none

module bitmap_indexed_block_allocator #(
    parameter int NUM_BLOCKS      = bia_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_DATA_BLOCKS = bia_pkg::MAX_DATA_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] block_count, [9:3] head_block, [15:10] zero
    input  logic [bia_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] req_type
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [6:0] granted_head, [13:7] data_block_0, [20:14] data_block_1,
    // [27:21] data_block_2, [34:28] data_block_3, [42:35] free_blocks, [47:43] zero
    output logic [bia_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] status
    output logic                          m_axis_tuser
);

    localparam int BLK_W   = $clog2(NUM_BLOCKS);
    localparam int FC_W    = $clog2(NUM_BLOCKS + 1);
    localparam int ENT_W   = (MAX_DATA_BLOCKS > 1) ? $clog2(MAX_DATA_BLOCKS) : 1;
    localparam int ROW_W   = MAX_DATA_BLOCKS * bia_pkg::CODE_W;
    localparam int CHUNK_W = bia_pkg::CHUNK_W;
    localparam int OFF_W   = bia_pkg::OFF_W;
    localparam int NCHUNK  = (NUM_BLOCKS + CHUNK_W - 1) / CHUNK_W;
    localparam int CI_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W   = (1 << CI_W) * CHUNK_W;
    localparam int CNT_W   = bia_pkg::COUNT_W;
    localparam int NUM_W   = bia_pkg::COUNT_W + 1;
    localparam int BN_W    = bia_pkg::BLK_NUM_W;
    localparam int CODE_W  = bia_pkg::CODE_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CHECK  = 8'b0000_0010,
        ST_SCAN   = 8'b0000_0100,
        ST_HREAD  = 8'b0000_1000,
        ST_HLATCH = 8'b0001_0000,
        ST_WALK   = 8'b0010_0000,
        ST_HWRITE = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t                                   state_reg, state_next;
    logic                                     req_reg, req_next;
    logic [CNT_W-1:0]                         cnt_reg, cnt_next;
    logic [BN_W-1:0]                          head_in_reg, head_in_next;
    logic [BLK_W-1:0]                         blk_reg, blk_next;
    logic                                     ok_reg, ok_next;
    logic                                     refused_reg, refused_next;
    logic [CI_W-1:0]                          chunk_reg, chunk_next;
    logic [NUM_W-1:0]                         n_reg, n_next;
    logic [CNT_W-1:0]                         i_reg, i_next;
    bia_pkg::code_t [MAX_DATA_BLOCKS-1:0]     ptr_reg, ptr_next;
    bia_pkg::code_t [MAX_DATA_BLOCKS-1:0]     row_reg, row_next;
    logic [NUM_BLOCKS-1:0]                    used_reg, used_next;
    logic [NUM_BLOCKS-1:0]                    valid_reg, valid_next;
    logic [FC_W-1:0]                          free_cnt_reg, free_cnt_next;

    logic [CNT_W-1:0]                         cnt_sat;
    logic [PAD_W-1:0]                         map_pad;
    logic [CHUNK_W-1:0]                       chunk_bits;
    bia_pkg::scan_res_t                       scan_res;
    logic [BLK_W-1:0]                         found_blk;
    logic [ENT_W-1:0]                         ent;
    bia_pkg::code_t                           k_code;
    logic                                     k_ok;
    logic [BLK_W-1:0]                         kidx;

    logic                                     wr_en, rd_en;
    logic [BLK_W-1:0]                         wr_addr, rd_addr;
    logic [ROW_W-1:0]                         wr_data, rd_data;
    bia_pkg::code_t [MAX_DATA_BLOCKS-1:0]     rd_row;

    logic [BN_W-1:0]                          slot [bia_pkg::OUT_SLOTS];

    bia_scan u_scan (
        .used_bits (chunk_bits),
        .res       (scan_res)
    );

    bia_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BLOCKS)
    ) u_rows (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_row = rd_data;

    assign cnt_sat = (32'(s_axis_tdata[CNT_W-1:0]) > MAX_DATA_BLOCKS)
                   ? CNT_W'(MAX_DATA_BLOCKS) : s_axis_tdata[CNT_W-1:0];

    // pad the bitmap with used bits past the last block
    always_comb
    begin
        map_pad                   = '1;
        map_pad[NUM_BLOCKS-1:0]   = used_reg;
    end

    assign chunk_bits = map_pad[{chunk_reg, OFF_W'(0)} +: CHUNK_W];
    assign found_blk  = BLK_W'({chunk_reg, scan_res.off});

    assign ent    = ENT_W'(i_reg);
    assign k_code = row_reg[ent];
    assign k_ok   = (k_code != bia_pkg::CODE_UNUSED) && (k_code != bia_pkg::CODE_DATA)
                 && (32'(k_code) < NUM_BLOCKS);
    assign kidx   = BLK_W'(k_code);

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        cnt_next      = cnt_reg;
        head_in_next  = head_in_reg;
        blk_next      = blk_reg;
        ok_next       = ok_reg;
        refused_next  = refused_reg;
        chunk_next    = chunk_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        ptr_next      = ptr_reg;
        row_next      = row_reg;
        used_next     = used_reg;
        valid_next    = valid_reg;
        free_cnt_next = free_cnt_reg;
        wr_en         = 1'b0;
        wr_addr       = blk_reg;
        wr_data       = row_reg;
        rd_en         = 1'b0;
        rd_addr       = blk_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next     = s_axis_tuser;
                    cnt_next     = cnt_sat;
                    head_in_next = s_axis_tdata[CNT_W +: BN_W];
                    blk_next     = BLK_W'(s_axis_tdata[CNT_W +: BN_W]);
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                chunk_next   = '0;
                n_next       = '0;
                i_next       = '0;
                ok_next      = 1'b0;
                refused_next = bia_pkg::STATUS_DONE;
                if (req_reg == bia_pkg::REQ_ALLOC)
                begin
                    if (32'(free_cnt_reg) < 32'(cnt_reg) + 1)
                    begin
                        refused_next = bia_pkg::STATUS_NO_SPACE;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        ok_next    = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
                else if (32'(head_in_reg) < NUM_BLOCKS)
                begin
                    used_next[blk_reg] = 1'b0;
                    free_cnt_next      = free_cnt_reg + FC_W'(used_reg[blk_reg]);
                    state_next         = ST_HREAD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SCAN:
            begin
                if (scan_res.found)
                begin
                    used_next[found_blk] = 1'b1;
                    free_cnt_next        = free_cnt_reg - FC_W'(1);
                    n_next               = n_reg + NUM_W'(1);
                    if (n_reg == '0)
                    begin
                        blk_next     = found_blk;
                        head_in_next = BN_W'(found_blk);
                    end
                    else
                    begin
                        ptr_next[ENT_W'(n_reg - NUM_W'(1))] = CODE_W'(found_blk);
                        wr_en                 = 1'b1;
                        wr_addr               = found_blk;
                        wr_data               = {MAX_DATA_BLOCKS{bia_pkg::CODE_DATA}};
                        valid_next[found_blk] = 1'b1;
                    end
                    if (n_reg == NUM_W'(cnt_reg))
                    begin
                        state_next = ST_HREAD;
                    end
                end
                else
                begin
                    chunk_next = chunk_reg + CI_W'(1);
                end
            end
            ST_HREAD:
            begin
                rd_en      = 1'b1;
                state_next = ST_HLATCH;
            end
            ST_HLATCH:
            begin
                for (int j = 0; j < MAX_DATA_BLOCKS; j++)
                begin
                    if (ok_reg && (32'(cnt_reg) > j))
                    begin
                        row_next[j] = ptr_reg[j];
                    end
                    else if (valid_reg[blk_reg])
                    begin
                        row_next[j] = rd_row[j];
                    end
                    else
                    begin
                        row_next[j] = bia_pkg::CODE_UNUSED;
                    end
                end
                state_next = (ok_reg || (cnt_reg == '0)) ? ST_HWRITE : ST_WALK;
            end
            ST_WALK:
            begin
                row_next[ent] = bia_pkg::CODE_UNUSED;
                if (k_ok)
                begin
                    used_next[kidx]  = 1'b0;
                    valid_next[kidx] = 1'b0;
                    free_cnt_next    = free_cnt_reg + FC_W'(used_reg[kidx]);
                    // index row pointing at itself: whole row goes unused
                    if (kidx == blk_reg)
                    begin
                        row_next = {MAX_DATA_BLOCKS{bia_pkg::CODE_UNUSED}};
                    end
                end
                i_next = i_reg + CNT_W'(1);
                if (i_reg + CNT_W'(1) == cnt_reg)
                begin
                    state_next = ST_HWRITE;
                end
            end
            ST_HWRITE:
            begin
                wr_en               = 1'b1;
                wr_addr             = blk_reg;
                wr_data             = row_reg;
                valid_next[blk_reg] = 1'b1;
                state_next          = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ok_reg       <= 1'b0;
            refused_reg  <= bia_pkg::STATUS_DONE;
            used_reg     <= '0;
            valid_reg    <= '0;
            free_cnt_reg <= FC_W'(NUM_BLOCKS);
        end
        else
        begin
            state_reg    <= state_next;
            ok_reg       <= ok_next;
            refused_reg  <= refused_next;
            used_reg     <= used_next;
            valid_reg    <= valid_next;
            free_cnt_reg <= free_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        cnt_reg     <= cnt_next;
        head_in_reg <= head_in_next;
        blk_reg     <= blk_next;
        chunk_reg   <= chunk_next;
        n_reg       <= n_next;
        i_reg       <= i_next;
        ptr_reg     <= ptr_next;
        row_reg     <= row_next;
    end

    for (genvar s = 0; s < bia_pkg::OUT_SLOTS; s++)
    begin : g_slot
        if (s < MAX_DATA_BLOCKS)
        begin : g_used
            assign slot[s] = (ok_reg && (32'(cnt_reg) > s)) ? BN_W'(ptr_reg[s]) : '0;
        end
        else
        begin : g_zero
            assign slot[s] = '0;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tuser  = refused_reg;
    assign m_axis_tdata  = {5'b0, bia_pkg::FREE_W'(free_cnt_reg),
                            slot[3], slot[2], slot[1], slot[0], head_in_reg};

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output sides active together");

    a_free_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(~used_reg) == 32'(free_cnt_reg))
        else $error("free count out of step with bitmap");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> 32'(chunk_reg) < NCHUNK)
        else $error("scan ran past last chunk");

    a_refuse_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (req_reg == bia_pkg::REQ_ALLOC) && !ok_reg)
        else $error("no-space status on a request that is not a refused allocate");

endmodule

`default_nettype wire
